// ===== rtl/tanh_activation_fwd_bwd_assert.svh =====
// Assertion macros for the tanh activation RTL, included by tafb_finish.
`ifndef TANH_ACTIVATION_FWD_BWD_ASSERT_SVH
`define TANH_ACTIVATION_FWD_BWD_ASSERT_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/tafb_pkg.sv =====
// Types, constants and tanh table for the tanh activation pipeline.
package tafb_pkg;

    localparam int FRAC_BITS  = 12;
    localparam int SEGMENTS   = 64;
    localparam int STEP_SHIFT = 8;

    localparam int DATA_W  = 16;
    localparam int MAG_W   = DATA_W - 1;
    localparam int IDX_W   = $clog2(SEGMENTS);
    localparam int ROM_W   = FRAC_BITS + 1;
    localparam int SLOPE_W = STEP_SHIFT + 1;
    localparam int FPROD_W = SLOPE_W + STEP_SHIFT;
    localparam int SQ_W    = 2 * DATA_W - 1;
    localparam int YSQ_W   = SQ_W - FRAC_BITS;
    localparam int DERIV_W = YSQ_W + 1;
    localparam int BPROD_W = DATA_W + DERIV_W;

    typedef enum logic
    {
        REQ_FWD = 1'b0,
        REQ_BWD = 1'b1
    } req_t;

    localparam logic [ROM_W-1:0] TANH_ROM [0:SEGMENTS] = '{
        13'd0,    13'd256,  13'd509,  13'd759,  13'd1003, 13'd1240, 13'd1468, 13'd1686,
        13'd1893, 13'd2088, 13'd2272, 13'd2443, 13'd2602, 13'd2748, 13'd2883, 13'd3007,
        13'd3119, 13'd3222, 13'd3315, 13'd3399, 13'd3475, 13'd3543, 13'd3604, 13'd3659,
        13'd3707, 13'd3751, 13'd3790, 13'd3825, 13'd3856, 13'd3883, 13'd3908, 13'd3929,
        13'd3949, 13'd3966, 13'd3981, 13'd3994, 13'd4006, 13'd4016, 13'd4026, 13'd4034,
        13'd4041, 13'd4048, 13'd4053, 13'd4058, 13'd4063, 13'd4067, 13'd4070, 13'd4073,
        13'd4076, 13'd4078, 13'd4080, 13'd4082, 13'd4084, 13'd4085, 13'd4086, 13'd4088,
        13'd4089, 13'd4089, 13'd4090, 13'd4091, 13'd4091, 13'd4092, 13'd4092, 13'd4093,
        13'd4093
    };

    typedef struct packed
    {
        req_t                      req;
        logic                      neg;
        logic                      big;
        logic [IDX_W-1:0]          idx;
        logic [STEP_SHIFT-1:0]     frac;
        logic signed [DATA_W-1:0]  dy;
        logic [SQ_W-1:0]           ysq_prod;
    } s1_t;

    typedef struct packed
    {
        req_t                      req;
        logic                      neg;
        logic                      big;
        logic [ROM_W-1:0]          base;
        logic [SLOPE_W-1:0]        slope;
        logic [STEP_SHIFT-1:0]     frac;
        logic signed [DATA_W-1:0]  dy;
        logic signed [DERIV_W-1:0] deriv;
    } s2_t;

    typedef struct packed
    {
        req_t                      req;
        logic                      neg;
        logic                      big;
        logic [ROM_W-1:0]          base;
        logic [FPROD_W-1:0]        fprod;
        logic signed [BPROD_W-1:0] bprod;
    } s3_t;

endpackage

// ===== rtl/tafb_decode.sv =====
// Stage 1: magnitude split of x and the exact square of y.
module tafb_decode
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_req,
    input  logic signed [15:0]            in_a,
    input  logic signed [15:0]            in_dy,
    output logic                          out_valid,
    input  logic                          out_ready,
    output tafb_pkg::s1_t                 out_stage
);
    import tafb_pkg::*;

    logic                      valid_reg;
    s1_t                       data_reg;
    s1_t                       data_next;
    logic [DATA_W-1:0]         neg_a;
    logic [MAG_W-1:0]          mag;
    logic signed [2*DATA_W-1:0] sq;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        neg_a = DATA_W'(-in_a);
        if (in_a == {1'b1, {MAG_W{1'b0}}})
        begin
            mag = {MAG_W{1'b1}};
        end
        else if (in_a[DATA_W-1])
        begin
            mag = neg_a[MAG_W-1:0];
        end
        else
        begin
            mag = in_a[MAG_W-1:0];
        end
        sq = in_a * in_a;

        data_next.req      = req_t'(in_req);
        data_next.neg      = in_a[DATA_W-1];
        data_next.big      = (mag >= MAG_W'(SEGMENTS << STEP_SHIFT));
        data_next.idx      = mag[STEP_SHIFT +: IDX_W];
        data_next.frac     = mag[STEP_SHIFT-1:0];
        data_next.dy       = in_dy;
        data_next.ysq_prod = sq[SQ_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_stage = data_reg;

endmodule

// ===== rtl/tafb_lookup.sv =====
// Stage 2: table lookup of base and slope, rounding of y squared into 1 - y^2.
module tafb_lookup
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  tafb_pkg::s1_t                 in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output tafb_pkg::s2_t                 out_stage
);
    import tafb_pkg::*;

    logic              valid_reg;
    s2_t               data_reg;
    s2_t               data_next;
    logic [ROM_W-1:0]  base;
    logic [ROM_W-1:0]  upper;
    logic [ROM_W-1:0]  diff;
    logic [SQ_W-1:0]   sq_round;
    logic [YSQ_W-1:0]  ysq;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        base     = TANH_ROM[in_data.idx];
        upper    = TANH_ROM[{1'b0, in_data.idx} + (IDX_W+1)'(1)];
        diff     = upper - base;
        sq_round = in_data.ysq_prod + SQ_W'(1 << (FRAC_BITS - 1));
        ysq      = sq_round[SQ_W-1:FRAC_BITS];

        data_next.req   = in_data.req;
        data_next.neg   = in_data.neg;
        data_next.big   = in_data.big;
        data_next.base  = base;
        data_next.slope = diff[SLOPE_W-1:0];
        data_next.frac  = in_data.frac;
        data_next.dy    = in_data.dy;
        data_next.deriv = DERIV_W'(1 << FRAC_BITS) - $signed({1'b0, ysq});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_stage = data_reg;

endmodule

// ===== rtl/tafb_mult.sv =====
// Stage 3: interpolation product and gradient product.
module tafb_mult
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  tafb_pkg::s2_t                 in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output tafb_pkg::s3_t                 out_stage
);
    import tafb_pkg::*;

    logic                       valid_reg;
    s3_t                        data_reg;
    s3_t                        data_next;
    logic signed [BPROD_W-1:0]  dy_ext;
    logic signed [BPROD_W-1:0]  deriv_ext;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        dy_ext    = BPROD_W'($signed(in_data.dy));
        deriv_ext = BPROD_W'($signed(in_data.deriv));

        data_next.req   = in_data.req;
        data_next.neg   = in_data.neg;
        data_next.big   = in_data.big;
        data_next.base  = in_data.base;
        data_next.fprod = FPROD_W'(in_data.slope) * FPROD_W'(in_data.frac);
        data_next.bprod = dy_ext * deriv_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_stage = data_reg;

endmodule

// ===== rtl/tafb_finish.sv =====
// Stage 4: rounding, sign restore, saturation and the result register.
`include "tanh_activation_fwd_bwd_assert.svh"

module tafb_finish
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  tafb_pkg::s3_t                 in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [15:0]            out_result
);
    import tafb_pkg::*;

    localparam int G_W = BPROD_W - FRAC_BITS;

    logic                      valid_reg;
    logic signed [DATA_W-1:0]  result_reg;
    logic signed [DATA_W-1:0]  result_next;
    req_t                      req_reg;
    logic                      big_reg;
    logic [FPROD_W-1:0]        f_round;
    logic [ROM_W-1:0]          mag_r;
    logic signed [BPROD_W-1:0] b_round;
    logic signed [G_W-1:0]     grad;
    logic                      fwd_out;
    logic                      fwd_in_range;
    logic                      fwd_at_max;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        f_round = in_data.fprod + FPROD_W'(1 << (STEP_SHIFT - 1));
        if (in_data.big)
        begin
            mag_r = TANH_ROM[SEGMENTS];
        end
        else
        begin
            mag_r = in_data.base + ROM_W'(f_round[FPROD_W-1:STEP_SHIFT]);
        end

        b_round = in_data.bprod + BPROD_W'(1 << (FRAC_BITS - 1));
        grad    = b_round[BPROD_W-1:FRAC_BITS];

        case (in_data.req)
            REQ_FWD:
            begin
                if (in_data.neg)
                begin
                    result_next = -$signed(DATA_W'(mag_r));
                end
                else
                begin
                    result_next = $signed(DATA_W'(mag_r));
                end
            end
            REQ_BWD:
            begin
                if (grad > G_W'(32767))
                begin
                    result_next = 16'sh7fff;
                end
                else if (grad < -G_W'(32768))
                begin
                    result_next = 16'sh8000;
                end
                else
                begin
                    result_next = grad[DATA_W-1:0];
                end
            end
            default:
            begin
                result_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            result_reg <= result_next;
            req_reg    <= in_data.req;
            big_reg    <= in_data.big;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    assign fwd_out      = valid_reg && (req_reg == REQ_FWD);
    assign fwd_in_range = (result_reg <= 16'sd4093) && (result_reg >= -16'sd4093);
    assign fwd_at_max   = (result_reg == 16'sd4093) || (result_reg == -16'sd4093);

    `ASSERT_NEXT(a_fill, clk, rst_n, in_valid && in_ready, valid_reg)
    `ASSERT_IMPLIES(a_fwd_range, clk, rst_n, fwd_out, fwd_in_range)
    `ASSERT_IMPLIES(a_fwd_big, clk, rst_n, fwd_out && big_reg, fwd_at_max)

endmodule

// ===== rtl/tanh_activation_fwd_bwd.sv =====
// Top level of the Q4.12 tanh forward and backward activation pipeline.
//
//   channel | valid     | ready     | payload
//   --------+-----------+-----------+------------------------------------
//   request | req_valid | req_ready | req_type, value_a, upstream_grad
//   result  | rsp_valid | rsp_ready | result
//
// One beat per cycle sustained while rsp_ready stays high.
// Four register stages: decode and y*y, table lookup, products, rounding/output.
// Each stage holds its beat while the next one is full and stalled; bubbles close up.
// Reset clears only the stage valid bits; no clearing pass.
module tanh_activation_fwd_bwd
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic                req_type,
    input  logic signed [15:0]  value_a,
    input  logic signed [15:0]  upstream_grad,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output logic signed [15:0]  result
);
    import tafb_pkg::*;

    logic  s1_valid;
    logic  s1_ready;
    s1_t   s1_data;
    logic  s2_valid;
    logic  s2_ready;
    s2_t   s2_data;
    logic  s3_valid;
    logic  s3_ready;
    s3_t   s3_data;

    tafb_decode u_decode
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req_valid),
        .in_ready  (req_ready),
        .in_req    (req_type),
        .in_a      (value_a),
        .in_dy     (upstream_grad),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_stage (s1_data)
    );

    tafb_lookup u_lookup
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_stage (s2_data)
    );

    tafb_mult u_mult
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .out_valid (s3_valid),
        .out_ready (s3_ready),
        .out_stage (s3_data)
    );

    tafb_finish u_finish
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s3_valid),
        .in_ready   (s3_ready),
        .in_data    (s3_data),
        .out_valid  (rsp_valid),
        .out_ready  (rsp_ready),
        .out_result (result)
    );

endmodule

// ===== tb/tb_tanh_activation_fwd_bwd.sv =====
// Testbench for the Q4.12 tanh forward/backward activation pipeline.
`timescale 1ns / 100ps

module tb_tanh_activation_fwd_bwd;

    import tafb_pkg::req_t;
    import tafb_pkg::REQ_FWD;
    import tafb_pkg::REQ_BWD;

    localparam int  Q_FRAC      = 12;
    localparam int  LUT_LAST    = 64;
    localparam int  SEG_SHIFT   = 8;
    localparam int  RANDOM_ITEMS = 282;
    localparam int  DRAIN_LIMIT = 4000;
    localparam int  PRINT_LIMIT = 40;
    localparam real RUN_LIMIT_NS = 5.0e6;

    localparam int TANH_POINTS [0:LUT_LAST] = '{
        0, 256, 509, 759, 1003, 1240, 1468, 1686,
        1893, 2088, 2272, 2443, 2602, 2748, 2883, 3007,
        3119, 3222, 3315, 3399, 3475, 3543, 3604, 3659,
        3707, 3751, 3790, 3825, 3856, 3883, 3908, 3929,
        3949, 3966, 3981, 3994, 4006, 4016, 4026, 4034,
        4041, 4048, 4053, 4058, 4063, 4067, 4070, 4073,
        4076, 4078, 4080, 4082, 4084, 4085, 4086, 4088,
        4089, 4089, 4090, 4091, 4091, 4092, 4092, 4093,
        4093
    };

    typedef struct
    {
        req_t               kind;
        logic signed [15:0] arg;
        logic signed [15:0] grad;
        logic signed [15:0] value;
    } pending_t;

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_ready;
    logic               req_type;
    logic signed [15:0] value_a;
    logic signed [15:0] upstream_grad;
    logic               rsp_valid;
    logic               rsp_ready;
    logic signed [15:0] result;

    pending_t pending_results [$];
    int       mismatch_count;
    int       send_idle_pct;
    int       recv_stall_pct;

    tanh_activation_fwd_bwd u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .req_type      (req_type),
        .value_a       (value_a),
        .upstream_grad (upstream_grad),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .result        (result)
    );

    always #10 clk = ~clk;

    function automatic logic signed [15:0] tanh_interp(input logic signed [15:0] x);
        longint mag;
        longint idx;
        longint frac;
        longint base;
        longint slope;
        longint r;
        mag = (x < 0) ? -longint'(x) : longint'(x);
        if (mag > 32767)
            mag = 32767;
        if (mag >= (LUT_LAST << SEG_SHIFT))
        begin
            r = TANH_POINTS[LUT_LAST];
        end
        else
        begin
            idx   = mag >> SEG_SHIFT;
            frac  = mag & ((1 << SEG_SHIFT) - 1);
            base  = TANH_POINTS[idx];
            slope = TANH_POINTS[idx + 1] - base;
            r     = base + ((slope * frac + (1 << (SEG_SHIFT - 1))) >>> SEG_SHIFT);
        end
        if (x < 0)
            r = -r;
        return 16'(r);
    endfunction

    function automatic logic signed [15:0] tanh_grad(input logic signed [15:0] y,
                                                     input logic signed [15:0] dy);
        longint ysq;
        longint deriv;
        longint g;
        ysq   = (longint'(y) * longint'(y) + (1 << (Q_FRAC - 1))) >>> Q_FRAC;
        deriv = (longint'(1) << Q_FRAC) - ysq;
        g     = (longint'(dy) * deriv + (1 << (Q_FRAC - 1))) >>> Q_FRAC;
        if (g > 32767)
            g = 32767;
        else if (g < -32768)
            g = -32768;
        return 16'(g);
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Hold valid and payload until the beat is taken.
    task automatic send_beat(input req_t kind, input logic signed [15:0] arg,
                             input logic signed [15:0] grad);
        pending_t item;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid     <= 1'b1;
        req_type      <= kind;
        value_a       <= arg;
        upstream_grad <= grad;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        item.kind  = kind;
        item.arg   = arg;
        item.grad  = grad;
        item.value = (kind == REQ_BWD) ? tanh_grad(arg, grad) : tanh_interp(arg);
        pending_results.push_back(item);
    endtask

    task automatic drain_results();
        int spin;
        spin = 0;
        req_valid <= 1'b0;
        while (pending_results.size() != 0 && spin < DRAIN_LIMIT)
        begin
            @(posedge clk);
            spin++;
        end
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    endtask

    always @(posedge clk)
    begin
        pending_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result %0d", result));
            end
            else
            begin
                want = pending_results.pop_front();
                if (result !== want.value)
                    report_mismatch($sformatf("%s a=%0d dy=%0d: result %0d, want %0d",
                                              want.kind.name(), want.arg, want.grad,
                                              result, want.value));
            end
        end
        rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic test_forward_corners();
        send_beat(REQ_FWD, 16'sh0000, 16'sh0000);
        send_beat(REQ_FWD, 16'sh0001, 16'sh7FFF);
        send_beat(REQ_FWD, 16'shFFFF, 16'sh8000);
        send_beat(REQ_FWD, 16'sh0080, 16'sh1234);
        send_beat(REQ_FWD, 16'sh00FF, 16'sh5555);
        send_beat(REQ_FWD, 16'sh0100, 16'shAAAA);
        send_beat(REQ_FWD, 16'sh3FFF, 16'shFFFF);
        send_beat(REQ_FWD, 16'sh4000, 16'sh0000);
        send_beat(REQ_FWD, 16'shC000, 16'sh7FFF);
        send_beat(REQ_FWD, 16'shC001, 16'sh0001);
        send_beat(REQ_FWD, 16'sh7FFF, 16'sh8000);
        send_beat(REQ_FWD, 16'sh8000, 16'sh4321);
        drain_results();
    endtask

    task automatic test_backward_corners();
        send_beat(REQ_BWD, 16'sh0000, 16'sh7FFF);
        send_beat(REQ_BWD, 16'sh0000, 16'sh8000);
        send_beat(REQ_BWD, 16'sh1000, 16'sh7FFF);
        send_beat(REQ_BWD, 16'shF000, 16'sh8000);
        send_beat(REQ_BWD, 16'sh0FFF, 16'sh3039);
        send_beat(REQ_BWD, 16'sh0800, 16'shFFFF);
        send_beat(REQ_BWD, 16'sh0001, 16'sh0001);
        send_beat(REQ_BWD, 16'sh2000, 16'sh03E8);
        send_beat(REQ_BWD, 16'sh7FFF, 16'sh7FFF);
        send_beat(REQ_BWD, 16'sh8000, 16'sh8000);
        send_beat(REQ_BWD, 16'sh8000, 16'sh7FFF);
        drain_results();
    endtask

    function automatic logic signed [15:0] pick_extreme();
        case ($urandom_range(5))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            4: return 16'sh1000;
            default: return 16'shF000;
        endcase
    endfunction

    function automatic logic signed [15:0] pick_forward_arg();
        logic signed [15:0] v;
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: v = 16'($urandom_range(16383));
            6, 7: return 16'($urandom);
            8: v = 16'(16384 + $urandom_range(8) - 4);
            default: return pick_extreme();
        endcase
        return $urandom_range(1) ? -v : v;
    endfunction

    function automatic logic signed [15:0] pick_backward_arg();
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5, 6: return 16'($urandom_range(8192) - 4096);
            7, 8: return 16'($urandom);
            default: return pick_extreme();
        endcase
    endfunction

    task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count);
        req_t               kind;
        logic signed [15:0] arg;
        logic signed [15:0] grad;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
        begin
            kind = req_t'($urandom_range(1));
            arg  = (kind == REQ_BWD) ? pick_backward_arg() : pick_forward_arg();
            grad = ($urandom_range(7) == 0) ? pick_extreme() : 16'($urandom);
            send_beat(kind, arg, grad);
        end
        // Pause the sender until every result is back.
        drain_results();
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        req_valid      = 1'b0;
        req_type       = REQ_FWD;
        value_a        = '0;
        upstream_grad  = '0;
        rsp_ready      = 1'b0;
        mismatch_count = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_forward_corners();
        test_backward_corners();
        test_random_phase(0, 0, RANDOM_ITEMS);
        test_random_phase(48, 0, RANDOM_ITEMS);
        test_random_phase(0, 48, RANDOM_ITEMS);
        test_random_phase(28, 28, RANDOM_ITEMS);

        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/tafb_pkg.sv
rtl/tafb_decode.sv
rtl/tafb_lookup.sv
rtl/tafb_mult.sv
rtl/tafb_finish.sv
rtl/tanh_activation_fwd_bwd.sv
tb/tb_tanh_activation_fwd_bwd.sv
